FILE: hdl/assert_macros.svh
// Assertion macros shared by the box filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define BF_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("box filter assertion failed");

`define BF_ASSERT_NEVER(name, clk, rst, expr) \
   name: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("box filter forbidden condition seen");

`else

`define BF_ASSERT(name, clk, rst, prop)

`define BF_ASSERT_NEVER(name, clk, rst, expr)

`endif

`endif

FILE: hdl/boxf3_pkg.sv
// Constants and register codes of the 3x3 box filter.
package boxf3_pkg;

   localparam int DEFAULT_MAX_WIDTH  = 32;
   localparam int DEFAULT_PIXEL_BITS = 8;

   localparam int ROW_BITS        = 12;
   localparam int WIDTH_REG_BITS  = 6;
   localparam int HEIGHT_REG_BITS = 13;
   localparam int CSR_DATA_BITS   = 13;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int MAX_HEIGHT      = 4096;

   localparam logic [WIDTH_REG_BITS-1:0]  RESET_WIDTH  = WIDTH_REG_BITS'(32);
   localparam logic [HEIGHT_REG_BITS-1:0] RESET_HEIGHT = HEIGHT_REG_BITS'(32);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1
   } csr_index_type;

endpackage

FILE: hdl/box_filter_3x3_mean.sv
// 3x3 mean filter over a raster pixel stream with a column-pair line store.
// A transfer is registered in s1, its window sum in s2 and its mean in the output register.
// Throughput: one pixel per cycle unless rsp_stall holds the output; the last pixel of each row
// after the first adds a tail step, and the frame's last adds a flush of every line store column.
// Reset (synchronous): counters to zero, width and height to 32; the line store is not cleared.
`include "assert_macros.svh"

module box_filter_3x3_mean
   import boxf3_pkg::*;
#(
   parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
   parameter int PIXEL_BITS = DEFAULT_PIXEL_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [PIXEL_BITS-1:0]     req_pixel,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [PIXEL_BITS-1:0]     rsp_filtered_pixel,
   output logic [ROW_BITS-1:0]       rsp_out_row,
   output logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] rsp_out_column,
   output logic                      rsp_last_of_run
);

   localparam int COL_BITS    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int LINE_BITS   = 2 * PIXEL_BITS;
   localparam int CS_BITS     = PIXEL_BITS + 2;
   localparam int SUM_BITS    = PIXEL_BITS + 4;
   localparam int SHIFT       = PIXEL_BITS + 8;
   localparam int RECIP_BITS  = PIXEL_BITS + 6;
   localparam int PROD_BITS   = SUM_BITS + RECIP_BITS;
   localparam logic [RECIP_BITS-1:0] RECIP = RECIP_BITS'(((1 << SHIFT) + 8) / 9);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_COL   = 5'b00010,
      ST_TAIL  = 5'b00100,
      ST_FLUSH = 5'b01000,
      ST_FTAIL = 5'b10000
   } state_type;

   function automatic logic [COL_BITS-1:0] width_last(input logic [WIDTH_REG_BITS-1:0] v);
      logic [COL_BITS-1:0] r;
      if (v == '0) begin
         r = '0;
      end else if (int'(v) > MAX_WIDTH) begin
         r = COL_BITS'(MAX_WIDTH - 1);
      end else begin
         r = COL_BITS'(v - 1'b1);
      end
      return r;
   endfunction

   function automatic logic [ROW_BITS-1:0] height_last(input logic [HEIGHT_REG_BITS-1:0] v);
      logic [ROW_BITS-1:0] r;
      if (v == '0) begin
         r = '0;
      end else if (int'(v) > MAX_HEIGHT) begin
         r = ROW_BITS'(MAX_HEIGHT - 1);
      end else begin
         r = ROW_BITS'(v - 1'b1);
      end
      return r;
   endfunction

   logic [LINE_BITS-1:0]  line_mem [MAX_WIDTH];

   state_type             state_ff, state_in;
   logic [COL_BITS-1:0]   w_last_ff;
   logic [ROW_BITS-1:0]   h_last_ff;
   logic [COL_BITS-1:0]   col_ff;
   logic [ROW_BITS-1:0]   row_ff;

   logic [PIXEL_BITS-1:0] s1_pixel_ff;
   logic [COL_BITS-1:0]   s1_col_ff;
   logic [ROW_BITS-1:0]   s1_row_ff;
   logic                  s1_eof_ff;

   logic [LINE_BITS-1:0]  rd_ff;
   logic                  fwd_hit_ff;
   logic [LINE_BITS-1:0]  fwd_data_ff;

   logic [CS_BITS-1:0]    win1_ff, win2_ff;

   logic [COL_BITS-1:0]   frd_col_ff, fd_col_ff;
   logic                  frd_done_ff, fd_valid_ff;

   logic                  s2_valid_ff;
   logic [SUM_BITS-1:0]   s2_sum_ff;
   logic [ROW_BITS-1:0]   s2_row_ff;
   logic [COL_BITS-1:0]   s2_col_ff;
   logic                  s2_last_ff;

   logic                  rsp_valid_ff;
   logic [PIXEL_BITS-1:0] rsp_pixel_ff;
   logic [ROW_BITS-1:0]   rsp_row_ff;
   logic [COL_BITS-1:0]   rsp_col_ff;
   logic                  rsp_last_ff;

   logic                  out_ready, s2_ready;
   logic                  accept_ok, accept;
   logic                  col_step, tail_step, write_en;
   logic                  flush_issue, flush_start, consume;
   logic [COL_BITS-1:0]   step_col, rd_addr;
   logic [CS_BITS-1:0]    step_cs, normal_cs, flush_cs, win2_term, cs_term;
   logic [LINE_BITS-1:0]  rd_sel;
   logic [PIXEL_BITS-1:0] rd_hi, rd_lo;
   logic                  s1_eol, row_ge1, row_ge2;
   logic                  emit_valid, emit_last;
   logic [SUM_BITS-1:0]   emit_sum;
   logic [ROW_BITS-1:0]   emit_row;
   logic [COL_BITS-1:0]   emit_col;
   logic [PROD_BITS-1:0]  prod;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign s2_ready  = !s2_valid_ff || out_ready;

   assign rd_sel  = fwd_hit_ff ? fwd_data_ff : rd_ff;
   assign rd_hi   = rd_sel[LINE_BITS-1 -: PIXEL_BITS];
   assign rd_lo   = rd_sel[PIXEL_BITS-1:0];
   assign s1_eol  = (s1_col_ff == w_last_ff);
   assign row_ge1 = (s1_row_ff != '0);
   assign row_ge2 = (s1_row_ff > ROW_BITS'(1));

   assign normal_cs = CS_BITS'(row_ge2 ? rd_hi : '0) + CS_BITS'(row_ge1 ? rd_lo : '0)
                    + CS_BITS'(s1_pixel_ff);
   assign flush_cs  = CS_BITS'(row_ge1 ? rd_hi : '0) + CS_BITS'(rd_lo);

   always_comb begin
      state_in    = state_ff;
      accept_ok   = 1'b0;
      col_step    = 1'b0;
      tail_step   = 1'b0;
      write_en    = 1'b0;
      flush_issue = 1'b0;
      flush_start = 1'b0;
      consume     = 1'b0;
      step_col    = s1_col_ff;
      step_cs     = normal_cs;
      emit_valid  = 1'b0;
      emit_last   = 1'b0;
      emit_row    = s1_row_ff;
      emit_col    = w_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            accept_ok = 1'b1;
         end
         ST_COL: begin
            if (s2_ready) begin
               col_step   = 1'b1;
               write_en   = 1'b1;
               emit_valid = row_ge1 && (s1_col_ff != '0);
               emit_col   = s1_col_ff - 1'b1;
               emit_row   = s1_row_ff - 1'b1;
               emit_last  = !s1_eol;
               if (row_ge1 && s1_eol) begin
                  state_in = ST_TAIL;
               end else if (s1_eof_ff) begin
                  state_in    = ST_FLUSH;
                  flush_start = 1'b1;
               end else begin
                  state_in  = ST_IDLE;
                  accept_ok = 1'b1;
               end
            end
         end
         ST_TAIL: begin
            if (s2_ready) begin
               tail_step  = 1'b1;
               emit_valid = 1'b1;
               emit_row   = s1_row_ff - 1'b1;
               emit_last  = !s1_eof_ff;
               if (s1_eof_ff) begin
                  state_in    = ST_FLUSH;
                  flush_start = 1'b1;
               end else begin
                  state_in  = ST_IDLE;
                  accept_ok = 1'b1;
               end
            end
         end
         ST_FLUSH: begin
            consume     = fd_valid_ff && s2_ready;
            flush_issue = !frd_done_ff && (!fd_valid_ff || consume);
            if (consume) begin
               col_step   = 1'b1;
               step_col   = fd_col_ff;
               step_cs    = flush_cs;
               emit_valid = (fd_col_ff != '0);
               emit_col   = fd_col_ff - 1'b1;
               if (fd_col_ff == w_last_ff) begin
                  state_in = ST_FTAIL;
               end
            end
         end
         ST_FTAIL: begin
            if (s2_ready) begin
               tail_step  = 1'b1;
               emit_valid = 1'b1;
               emit_last  = 1'b1;
               state_in   = ST_IDLE;
               accept_ok  = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (req_valid && accept_ok) begin
         state_in = ST_COL;
      end
   end

   assign accept    = req_valid && accept_ok;
   assign req_stall = !accept_ok;
   assign rd_addr   = flush_issue ? frd_col_ff : col_ff;

   assign win2_term = (tail_step ? (w_last_ff != '0) : (step_col > COL_BITS'(1)))
                      ? win2_ff : '0;
   assign cs_term   = tail_step ? '0 : step_cs;
   assign emit_sum  = SUM_BITS'(win2_term) + SUM_BITS'(win1_ff) + SUM_BITS'(cs_term)
                    + SUM_BITS'(4);

   // line store: each entry holds {row above, current row} of one column
   always_ff @(posedge clock) begin
      if (write_en) begin
         line_mem[s1_col_ff] <= {rd_lo, s1_pixel_ff};
      end
      if (accept || flush_issue) begin
         rd_ff <= line_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         w_last_ff   <= width_last(RESET_WIDTH);
         h_last_ff   <= height_last(RESET_HEIGHT);
         col_ff      <= '0;
         row_ff      <= '0;
         fwd_hit_ff  <= 1'b0;
         frd_done_ff <= 1'b0;
         fd_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (csr_write_en && (csr_index == CSR_IMAGE_WIDTH)) begin
            w_last_ff <= width_last(csr_wdata[WIDTH_REG_BITS-1:0]);
            col_ff    <= '0;
            row_ff    <= '0;
         end else if (csr_write_en && (csr_index == CSR_IMAGE_HEIGHT)) begin
            h_last_ff <= height_last(csr_wdata[HEIGHT_REG_BITS-1:0]);
            col_ff    <= '0;
            row_ff    <= '0;
         end else if (accept) begin
            if (col_ff == w_last_ff) begin
               col_ff <= '0;
               row_ff <= (row_ff == h_last_ff) ? '0 : row_ff + 1'b1;
            end else begin
               col_ff <= col_ff + 1'b1;
            end
         end

         // forward the entry written this cycle to a transfer reading the same column
         if (accept) begin
            fwd_hit_ff <= write_en && (col_ff == s1_col_ff);
         end else if (flush_issue) begin
            fwd_hit_ff <= 1'b0;
         end

         if (flush_start) begin
            frd_done_ff <= 1'b0;
            fd_valid_ff <= 1'b0;
         end else if (flush_issue) begin
            frd_done_ff <= (frd_col_ff == w_last_ff);
            fd_valid_ff <= 1'b1;
         end else if (consume) begin
            fd_valid_ff <= 1'b0;
         end

         if (s2_ready) begin
            s2_valid_ff <= emit_valid;
         end
         if (out_ready) begin
            rsp_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff <= req_pixel;
         s1_col_ff   <= col_ff;
         s1_row_ff   <= row_ff;
         s1_eof_ff   <= (col_ff == w_last_ff) && (row_ff == h_last_ff);
         fwd_data_ff <= {rd_lo, s1_pixel_ff};
      end
      if (flush_start) begin
         frd_col_ff <= '0;
      end else if (flush_issue) begin
         frd_col_ff <= frd_col_ff + 1'b1;
         fd_col_ff  <= frd_col_ff;
      end
      if (col_step) begin
         win2_ff <= win1_ff;
         win1_ff <= step_cs;
      end
      if (s2_ready && emit_valid) begin
         s2_sum_ff  <= emit_sum;
         s2_row_ff  <= emit_row;
         s2_col_ff  <= emit_col;
         s2_last_ff <= emit_last;
      end
      if (out_ready && s2_valid_ff) begin
         rsp_pixel_ff <= prod[SHIFT +: PIXEL_BITS];
         rsp_row_ff   <= s2_row_ff;
         rsp_col_ff   <= s2_col_ff;
         rsp_last_ff  <= s2_last_ff;
      end
   end

   // divide by nine through the reciprocal
   assign prod = PROD_BITS'(s2_sum_ff) * PROD_BITS'(RECIP);

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_filtered_pixel = rsp_pixel_ff;
   assign rsp_out_row        = rsp_row_ff;
   assign rsp_out_column     = rsp_col_ff;
   assign rsp_last_of_run    = rsp_last_ff;

   `BF_ASSERT_NEVER(a_read_port_conflict, clock, reset, accept && flush_issue)
   `BF_ASSERT(a_flush_in_row, clock, reset, flush_issue |-> (frd_col_ff <= w_last_ff))
   `BF_ASSERT(a_eof_at_frame_end, clock, reset, ((state_ff == ST_COL) && s1_eof_ff) |-> ((s1_col_ff == w_last_ff) && (s1_row_ff == h_last_ff)))
   `BF_ASSERT(a_forward_after_write, clock, reset, fwd_hit_ff |-> $past(state_ff == ST_COL))

endmodule
